/* rtl/dotted_name_validator_macros.svh */
// Assertion macros shared by the checking code of the name validator.
`ifndef DOTTED_NAME_VALIDATOR_MACROS_SVH
`define DOTTED_NAME_VALIDATOR_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define DNV_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define DNV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dnv_pkg.sv */
package dnv_pkg;

   // field and register widths
   localparam int BYTE_WIDTH      = 8;
   localparam int LENGTH_WIDTH    = 8;
   localparam int TOTAL_WIDTH     = 9;
   localparam int SEGMENT_WIDTH   = 2;
   localparam int CSR_INDEX_WIDTH = 8;

   // byte codes and limits
   localparam logic [BYTE_WIDTH-1:0]    DOT_BYTE    = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0]    HYPHEN_BYTE = 8'h2D;
   localparam logic [SEGMENT_WIDTH-1:0] MIN_SEGMENT = 2'd3;
   localparam logic [TOTAL_WIDTH-1:0]   COUNT_SAT   = 9'd256;

   // register map
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_NAME_LENGTH = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_NAME_LENGTH = 8'd1;
   localparam logic [LENGTH_WIDTH-1:0]    MIN_LENGTH_RESET    = 8'd3;
   localparam logic [LENGTH_WIDTH-1:0]    MAX_LENGTH_RESET    = 8'd16;

   // queue between classifier and checker
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // character classes found by the front end
   typedef enum logic [2:0] {
      CLS_LOWER,
      CLS_DIGIT,
      CLS_HYPHEN,
      CLS_DOT,
      CLS_OTHER
   } char_class_type;

   // one classified request
   typedef struct packed {
      char_class_type cls;
      logic           final_byte;
   } entry_type;

   // queue status seen by front and back
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

/* rtl/dotted_name_validator.sv */
// Path: the final byte passes through the queue behind any requests ahead of it,
// and its verdict is registered onto rsp_valid. Throughput: one byte per cycle
// unless req_stall is high; the checker retires one queued request a cycle unless
// a final byte waits behind a stalled verdict. Reset: synchronous, active high;
// clears the queue, name state and rsp_valid; sets the length bounds to 3 and 16.
module dotted_name_validator #(
   parameter int QUEUE_DEPTH = dnv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dnv_pkg::BYTE_WIDTH-1:0]      req_name_byte,
   input  logic                                req_final_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_name_valid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dnv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dnv_pkg::LENGTH_WIDTH-1:0]    csr_data
);
   import dnv_pkg::*;

   logic [LENGTH_WIDTH-1:0] min_name_length_ff;
   logic [LENGTH_WIDTH-1:0] max_name_length_ff;
   queue_status_type        status;
   entry_type               push_entry;
   entry_type               head;
   logic                    push;
   logic                    pop;

   assign csr_ready = 1'b1;

   // write the length bounds; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_name_length_ff <= MIN_LENGTH_RESET;
         max_name_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MIN_NAME_LENGTH: min_name_length_ff <= csr_data;
            REG_MAX_NAME_LENGTH: max_name_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   dnv_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_name_byte  (req_name_byte),
      .req_final_byte (req_final_byte),
      .status         (status),
      .push           (push),
      .push_entry     (push_entry)
   );

   dnv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   dnv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .status          (status),
      .pop             (pop),
      .min_name_length (min_name_length_ff),
      .max_name_length (max_name_length_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_name_valid  (rsp_name_valid)
   );

endmodule

/* rtl/dnv_front.sv */
module dnv_front (
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dnv_pkg::BYTE_WIDTH-1:0]  req_name_byte,
   input  logic                            req_final_byte,
   input  dnv_pkg::queue_status_type       status,
   output logic                            push,
   output dnv_pkg::entry_type              push_entry
);
   import dnv_pkg::*;

   // hold the request back while the queue is full
   assign req_stall = status.full;
   assign push      = req_valid && !status.full;

   // classify the byte
   always_comb begin
      push_entry.final_byte = req_final_byte;
      if (req_name_byte >= 8'h61 && req_name_byte <= 8'h7A) begin
         push_entry.cls = CLS_LOWER;
      end else if (req_name_byte >= 8'h30 && req_name_byte <= 8'h39) begin
         push_entry.cls = CLS_DIGIT;
      end else if (req_name_byte == HYPHEN_BYTE) begin
         push_entry.cls = CLS_HYPHEN;
      end else if (req_name_byte == DOT_BYTE) begin
         push_entry.cls = CLS_DOT;
      end else begin
         push_entry.cls = CLS_OTHER;
      end
   end

endmodule

/* rtl/dnv_queue.sv */
module dnv_queue #(
   parameter int DEPTH = dnv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dnv_pkg::entry_type         push_entry,
   input  logic                       pop,
   output dnv_pkg::entry_type         head,
   output dnv_pkg::queue_status_type  status
);
   import dnv_pkg::*;

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_CNT  = COUNT_WIDTH'(DEPTH);

   entry_type              store_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == FULL_CNT);
   assign head             = store_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the entry
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/dnv_back.sv */
module dnv_back (
   input  logic                              clock,
   input  logic                              reset,
   input  dnv_pkg::entry_type                head,
   input  dnv_pkg::queue_status_type         status,
   output logic                              pop,
   input  logic [dnv_pkg::LENGTH_WIDTH-1:0]  min_name_length,
   input  logic [dnv_pkg::LENGTH_WIDTH-1:0]  max_name_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_name_valid
);
   import dnv_pkg::*;

   logic [TOTAL_WIDTH-1:0]   total_count_ff, total_count_in;
   logic [SEGMENT_WIDTH-1:0] segment_count_ff, segment_count_in;
   logic                     last_was_hyphen_ff, last_was_hyphen_in;
   logic                     failed_ff, failed_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_name_valid_ff, out_name_valid_in;
   logic                     char_ok;
   logic                     name_failed;

   // take the head unless a verdict would overwrite one still waiting
   assign pop = status.not_empty &&
                (!head.final_byte || !out_valid_ff || !rsp_stall);

   assign rsp_valid      = out_valid_ff;
   assign rsp_name_valid = out_name_valid_ff;

   // update the name state for the popped request
   always_comb begin
      total_count_in     = total_count_ff;
      segment_count_in   = segment_count_ff;
      last_was_hyphen_in = last_was_hyphen_ff;
      failed_in          = failed_ff;
      name_failed        = failed_ff;
      char_ok            = 1'b0;
      out_valid_in       = out_valid_ff && rsp_stall;
      out_name_valid_in  = out_name_valid_ff;
      if (pop) begin
         if (total_count_ff < COUNT_SAT) begin
            total_count_in = total_count_ff + 1'b1;
         end
         if (head.cls == CLS_DOT) begin
            // close the segment
            if (segment_count_ff < MIN_SEGMENT || last_was_hyphen_ff) begin
               failed_in = 1'b1;
            end
            segment_count_in   = '0;
            last_was_hyphen_in = 1'b0;
         end else begin
            if (segment_count_ff == '0) begin
               char_ok = (head.cls == CLS_LOWER);
            end else begin
               char_ok = (head.cls == CLS_LOWER) || (head.cls == CLS_DIGIT) ||
                         (head.cls == CLS_HYPHEN);
            end
            if (!char_ok) begin
               failed_in = 1'b1;
            end
            last_was_hyphen_in = (head.cls == CLS_HYPHEN);
            if (segment_count_ff < MIN_SEGMENT) begin
               segment_count_in = segment_count_ff + 1'b1;
            end
         end
         if (head.final_byte) begin
            // close the last segment and check the length bounds
            name_failed = failed_in;
            if (segment_count_in < MIN_SEGMENT || last_was_hyphen_in) begin
               name_failed = 1'b1;
            end
            if (total_count_in < {1'b0, min_name_length} ||
                total_count_in > {1'b0, max_name_length}) begin
               name_failed = 1'b1;
            end
            out_valid_in       = 1'b1;
            out_name_valid_in  = !name_failed;
            total_count_in     = '0;
            segment_count_in   = '0;
            last_was_hyphen_in = 1'b0;
            failed_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_count_ff     <= '0;
         segment_count_ff   <= '0;
         last_was_hyphen_ff <= 1'b0;
         failed_ff          <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         total_count_ff     <= total_count_in;
         segment_count_ff   <= segment_count_in;
         last_was_hyphen_ff <= last_was_hyphen_in;
         failed_ff          <= failed_in;
         out_valid_ff       <= out_valid_in;
      end
   end

   // hold the verdict
   always_ff @(posedge clock) begin
      out_name_valid_ff <= out_name_valid_in;
   end

endmodule

/* rtl/dnv_checker.sv */
`include "dotted_name_validator_macros.svh"

module dnv_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [dnv_pkg::BYTE_WIDTH-1:0]      req_name_byte,
   input logic                                req_final_byte,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_name_valid,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [dnv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [dnv_pkg::LENGTH_WIDTH-1:0]    csr_data
);
   import dnv_pkg::*;

   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_name_valid);
   endproperty

   property p_req_hold;
      req_valid && req_stall |=>
         req_valid && $stable(req_name_byte) && $stable(req_final_byte);
   endproperty

   property p_csr_known;
      csr_valid |-> !$isunknown(csr_index) && !$isunknown(csr_data);
   endproperty

   // a stalled verdict stays put
   `DNV_ASSERT_RST(a_rsp_hold, clock, reset, p_rsp_hold, "verdict changed while stalled")

   // a stalled request stays put
   `DNV_ASSERT_RST(a_req_hold, clock, reset, p_req_hold, "request changed while stalled")

   // reset leaves no verdict pending
   `DNV_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "verdict pending after reset")

   // configuration writes are never held off
   `DNV_ASSERT_RST(a_csr_ready, clock, reset, csr_ready, "configuration port not ready")

   // a configuration write carries known index and data
   `DNV_ASSERT_RST(a_csr_known, clock, reset, p_csr_known, "unknown configuration write")

endmodule

bind dotted_name_validator dnv_checker u_dnv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_name_byte  (req_name_byte),
   .req_final_byte (req_final_byte),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_name_valid (rsp_name_valid),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready),
   .csr_index      (csr_index),
   .csr_data       (csr_data)
);
